>>> rtl/sletx_pkg.sv
// ----------------------------------------------------------------------------
// sletx_pkg: shared types and constants for the SLIP transmit ring buffer
// Buffer geometry, command and register codes, and the structs that pass
// between the configuration bank, the engine and the byte store.
// ----------------------------------------------------------------------------
`default_nettype none

package sletx_pkg;

  // Ring buffer geometry
  localparam int unsigned DEPTH = 256;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned POS_W = PTR_W + 1;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DROP_W = 2;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_DATA  = 3'd0,
    CMD_BEGIN = 3'd1,
    CMD_END   = 3'd2,
    CMD_DONE  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_CODE_BEGIN   = 3'd0,
    REG_CODE_END     = 3'd1,
    REG_CODE_ESC     = 3'd2,
    REG_CODE_ESC_BEG = 3'd3,
    REG_CODE_ESC_END = 3'd4,
    REG_CODE_ESC_ESC = 3'd5
  } cfg_idx_t;

  // Reset values of the code registers
  localparam logic [BYTE_W-1:0] RST_CODE_BEGIN   = 8'd193;
  localparam logic [BYTE_W-1:0] RST_CODE_END     = 8'd192;
  localparam logic [BYTE_W-1:0] RST_CODE_ESC     = 8'd219;
  localparam logic [BYTE_W-1:0] RST_CODE_ESC_BEG = 8'd222;
  localparam logic [BYTE_W-1:0] RST_CODE_ESC_END = 8'd220;
  localparam logic [BYTE_W-1:0] RST_CODE_ESC_ESC = 8'd221;

  // Framing codes as seen by the engine
  typedef struct packed {
    logic [BYTE_W-1:0] code_begin;
    logic [BYTE_W-1:0] code_end;
    logic [BYTE_W-1:0] code_escape;
    logic [BYTE_W-1:0] code_esc_begin;
    logic [BYTE_W-1:0] code_esc_end;
    logic [BYTE_W-1:0] code_esc_escape;
  } codes_t;

  // Store access from the engine: one write port, one read address
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/sletx_cfg_regs.sv
// ----------------------------------------------------------------------------
// sletx_cfg_regs: framing code register bank
// Holds the six code bytes; writes to unused indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module sletx_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [sletx_pkg::IDX_W-1:0]    wr_index,
  input  wire logic [sletx_pkg::BYTE_W-1:0]   wr_data,
  output sletx_pkg::codes_t                   codes
);

  sletx_pkg::codes_t codes_r;

  // Load a code register on a write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.code_begin      <= sletx_pkg::RST_CODE_BEGIN;
      codes_r.code_end        <= sletx_pkg::RST_CODE_END;
      codes_r.code_escape     <= sletx_pkg::RST_CODE_ESC;
      codes_r.code_esc_begin  <= sletx_pkg::RST_CODE_ESC_BEG;
      codes_r.code_esc_end    <= sletx_pkg::RST_CODE_ESC_END;
      codes_r.code_esc_escape <= sletx_pkg::RST_CODE_ESC_ESC;
    end else if (wr_en) begin
      case (sletx_pkg::cfg_idx_t'(wr_index))
        sletx_pkg::REG_CODE_BEGIN:   codes_r.code_begin      <= wr_data;
        sletx_pkg::REG_CODE_END:     codes_r.code_end        <= wr_data;
        sletx_pkg::REG_CODE_ESC:     codes_r.code_escape     <= wr_data;
        sletx_pkg::REG_CODE_ESC_BEG: codes_r.code_esc_begin  <= wr_data;
        sletx_pkg::REG_CODE_ESC_END: codes_r.code_esc_end    <= wr_data;
        sletx_pkg::REG_CODE_ESC_ESC: codes_r.code_esc_escape <= wr_data;
        default: ;
      endcase
    end
  end

  assign codes = codes_r;

endmodule

`default_nettype wire

>>> rtl/sletx_store.sv
// ----------------------------------------------------------------------------
// sletx_store: ring buffer byte store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sletx_store (
  input  wire logic                           clk,
  input  wire sletx_pkg::mem_req_t            req,
  output logic [sletx_pkg::BYTE_W-1:0]        rdata
);

  logic [sletx_pkg::BYTE_W-1:0] mem [sletx_pkg::DEPTH];
  logic [sletx_pkg::BYTE_W-1:0] rdata_r;

  // Write the queued byte
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/sletx_engine.sv
// ----------------------------------------------------------------------------
// sletx_engine: item register, encoder, ring pointers and result register
// Encodes one command at a time, queues bytes into the store, tracks the
// head, tail and link state, and issues send requests.
// ----------------------------------------------------------------------------
`default_nettype none

module sletx_engine (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire sletx_pkg::codes_t               codes,
  // Input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sletx_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [sletx_pkg::BYTE_W-1:0]    in_payload_byte,
  input  wire logic [sletx_pkg::POS_W-1:0]     in_done_position,
  input  wire logic [sletx_pkg::PTR_W-1:0]     in_read_position,
  // Store access
  output sletx_pkg::mem_req_t                  mem_req,
  input  wire logic [sletx_pkg::BYTE_W-1:0]    mem_rdata,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_send_request,
  output logic [sletx_pkg::PTR_W-1:0]          out_run_start,
  output logic [sletx_pkg::POS_W-1:0]          out_run_stop,
  output logic [sletx_pkg::DROP_W-1:0]         out_dropped_bytes,
  output logic [sletx_pkg::BYTE_W-1:0]         out_read_byte
);

  localparam int unsigned PTR_W  = sletx_pkg::PTR_W;
  localparam int unsigned POS_W  = sletx_pkg::POS_W;
  localparam int unsigned BYTE_W = sletx_pkg::BYTE_W;
  localparam int unsigned DROP_W = sletx_pkg::DROP_W;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'b01,
    PH_SECOND = 2'b10
  } phase_t;

  // Item register
  logic                          s_vld_r;
  logic [sletx_pkg::CMD_W-1:0]   s_cmd_r;
  logic [BYTE_W-1:0]             s_data_r;
  logic [POS_W-1:0]              s_done_r;
  logic [PTR_W-1:0]              s_read_r;
  phase_t                        phase_r, phase_nxt;

  // Ring state
  logic [PTR_W-1:0]              head_r, head_nxt;
  logic [PTR_W-1:0]              tail_r, tail_nxt;
  logic                          busy_r, busy_nxt;

  // Partial results carried from the first half of an escape pair
  logic                          acc_req_r, acc_req_nxt;
  logic [PTR_W-1:0]              acc_start_r, acc_start_nxt;
  logic [POS_W-1:0]              acc_stop_r, acc_stop_nxt;
  logic [DROP_W-1:0]             acc_drop_r, acc_drop_nxt;

  // Result register
  logic                          out_vld_r;
  logic                          res_req_r;
  logic [PTR_W-1:0]              res_start_r;
  logic [POS_W-1:0]              res_stop_r;
  logic [DROP_W-1:0]             res_drop_r;
  logic [BYTE_W-1:0]             res_rd_r;

  // Pass outputs
  logic                          finish;
  logic                          res_req;
  logic [PTR_W-1:0]              res_start;
  logic [POS_W-1:0]              res_stop;
  logic [DROP_W-1:0]             res_drop;
  logic [BYTE_W-1:0]             res_rd;

  logic                          res_free;
  logic                          in_accept;
  logic                          first;
  logic                          is_queue;
  logic                          is_pair;
  logic                          is_two;
  logic                          step_en;
  logic                          full;
  logic [PTR_W-1:0]              head_inc;
  logic [PTR_W-1:0]              done_tail;
  logic [BYTE_W-1:0]             sub_byte;
  logic [BYTE_W-1:0]             q_byte;
  sletx_pkg::cmd_t               cmd;
  sletx_pkg::mem_req_t           mem_req_w;

  assign res_free  = !out_vld_r || !out_stall;
  assign in_stall  = s_vld_r && !finish;
  assign in_accept = in_valid && !in_stall;
  assign first     = (phase_r == PH_FIRST);
  assign cmd       = sletx_pkg::cmd_t'(s_cmd_r);

  // Classify the command and pick the byte to queue in this pass
  always_comb begin
    is_queue = (cmd == sletx_pkg::CMD_DATA) || (cmd == sletx_pkg::CMD_BEGIN) ||
               (cmd == sletx_pkg::CMD_END);
    is_pair  = (cmd == sletx_pkg::CMD_DATA) &&
               ((s_data_r == codes.code_begin) || (s_data_r == codes.code_end) ||
                (s_data_r == codes.code_escape));
    is_two   = is_pair || (cmd == sletx_pkg::CMD_READ);

    if (s_data_r == codes.code_begin) begin
      sub_byte = codes.code_esc_begin;
    end else if (s_data_r == codes.code_end) begin
      sub_byte = codes.code_esc_end;
    end else begin
      sub_byte = codes.code_esc_escape;
    end

    if (cmd == sletx_pkg::CMD_BEGIN) begin
      q_byte = codes.code_begin;
    end else if (cmd == sletx_pkg::CMD_END) begin
      q_byte = codes.code_end;
    end else if (is_pair) begin
      q_byte = first ? codes.code_escape : sub_byte;
    end else begin
      q_byte = s_data_r;
    end
  end

  // Pointer arithmetic
  assign head_inc  = (head_r == PTR_W'(sletx_pkg::DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign full      = (head_inc == tail_r);
  assign done_tail = (s_done_r >= POS_W'(sletx_pkg::DEPTH)) ? '0 : s_done_r[PTR_W-1:0];

  // The first pass of a pair or a read runs without the result register;
  // every finishing pass needs it
  assign step_en = s_vld_r && ((is_two && first) || res_free);

  // Main pass: queue, send done, read
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    acc_req_nxt   = acc_req_r;
    acc_start_nxt = acc_start_r;
    acc_stop_nxt  = acc_stop_r;
    acc_drop_nxt  = acc_drop_r;
    finish        = 1'b0;
    res_req       = 1'b0;
    res_start     = '0;
    res_stop      = '0;
    res_drop      = '0;
    res_rd        = '0;
    mem_req_w.we    = 1'b0;
    mem_req_w.waddr = head_r;
    mem_req_w.wdata = q_byte;
    mem_req_w.raddr = s_read_r;

    if (step_en) begin
      if (is_queue) begin
        // Carry results of the escape byte into the substitute pass
        if (is_pair && !first) begin
          res_req   = acc_req_r;
          res_start = acc_start_r;
          res_stop  = acc_stop_r;
          res_drop  = acc_drop_r;
        end
        if (full) begin
          res_drop = res_drop + DROP_W'(1);
        end else begin
          mem_req_w.we = 1'b1;
          head_nxt     = head_inc;
          if (!busy_r && (tail_r != head_inc)) begin
            busy_nxt  = 1'b1;
            res_req   = 1'b1;
            res_start = tail_r;
            res_stop  = (tail_r < head_inc) ? {1'b0, head_inc} : POS_W'(sletx_pkg::DEPTH);
          end
        end
        if (is_pair && first) begin
          acc_req_nxt   = res_req;
          acc_start_nxt = res_start;
          acc_stop_nxt  = res_stop;
          acc_drop_nxt  = res_drop;
          phase_nxt     = PH_SECOND;
        end else begin
          finish    = 1'b1;
          phase_nxt = PH_FIRST;
        end
      end else begin
        case (cmd)
          sletx_pkg::CMD_DONE: begin
            // Move the tail and restart the link if data waits
            tail_nxt = done_tail;
            busy_nxt = 1'b0;
            if (done_tail != head_r) begin
              busy_nxt  = 1'b1;
              res_req   = 1'b1;
              res_start = done_tail;
              res_stop  = (done_tail < head_r) ? {1'b0, head_r} :
                          POS_W'(sletx_pkg::DEPTH);
            end
            finish = 1'b1;
          end
          sletx_pkg::CMD_READ: begin
            // Address in the first pass, data in the second
            if (first) begin
              phase_nxt = PH_SECOND;
            end else begin
              res_rd    = mem_rdata;
              finish    = 1'b1;
              phase_nxt = PH_FIRST;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
    end
  end

  assign mem_req = mem_req_w;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r   <= 1'b0;
      phase_r   <= PH_FIRST;
      head_r    <= '0;
      tail_r    <= '0;
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s_vld_r <= 1'b1;
      end else if (finish) begin
        s_vld_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      busy_r  <= busy_nxt;
      if (finish) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload: item capture, pair carry, result hold
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_cmd_r  <= in_cmd;
      s_data_r <= in_payload_byte;
      s_done_r <= in_done_position;
      s_read_r <= in_read_position;
    end
    acc_req_r   <= acc_req_nxt;
    acc_start_r <= acc_start_nxt;
    acc_stop_r  <= acc_stop_nxt;
    acc_drop_r  <= acc_drop_nxt;
    if (finish) begin
      res_req_r   <= res_req;
      res_start_r <= res_start;
      res_stop_r  <= res_stop;
      res_drop_r  <= res_drop;
      res_rd_r    <= res_rd;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_send_request  = res_req_r;
  assign out_run_start     = res_start_r;
  assign out_run_stop      = res_stop_r;
  assign out_dropped_bytes = res_drop_r;
  assign out_read_byte     = res_rd_r;

`ifndef SYNTHESIS
  // The second pass only exists while an item is held
  a_phase_item: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SECOND) |-> s_vld_r)
    else $error("second pass without a held item");

  // A stored byte never makes the ring look empty
  a_write_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req_w.we |=> (head_r != tail_r))
    else $error("write left head equal to tail");

  // A request marks the link busy
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && res_req) |=> busy_r)
    else $error("send request without busy link");

  // A requested run is never empty
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_req_r) |-> (res_stop_r > {1'b0, res_start_r}))
    else $error("empty send run");

  // At most two bytes drop per item
  a_drop_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_drop_r != 2'd3))
    else $error("drop count out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/slip_escape_tx_ring_buffer.sv
// ----------------------------------------------------------------------------
// slip_escape_tx_ring_buffer: SLIP transmit framer with a ring buffer
// Encodes packet markers and data bytes into a 256-entry ring buffer and
// issues send requests for contiguous runs to an idle link.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   cmd, payload_byte, done/read pos
//   out_     output     out_valid / out_stall request, run, drops, read byte
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An escaped byte is queued as an escape pass then a substitute pass because
// the store has a single write port, and a read uses an address pass then a
// data pass because the store's read data is registered.
// Reset clears pointers, link state and codes; the store is not cleared.
// The result register holds under out_stall; a held result stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module slip_escape_tx_ring_buffer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sletx_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [sletx_pkg::BYTE_W-1:0]    in_payload_byte,
  input  wire logic [sletx_pkg::POS_W-1:0]     in_done_position,
  input  wire logic [sletx_pkg::PTR_W-1:0]     in_read_position,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_send_request,
  output logic [sletx_pkg::PTR_W-1:0]          out_run_start,
  output logic [sletx_pkg::POS_W-1:0]          out_run_stop,
  output logic [sletx_pkg::DROP_W-1:0]         out_dropped_bytes,
  output logic [sletx_pkg::BYTE_W-1:0]         out_read_byte,
  // Configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sletx_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [sletx_pkg::BYTE_W-1:0]    cfg_data
);

  sletx_pkg::codes_t            codes;
  sletx_pkg::mem_req_t          mem_req;
  logic [sletx_pkg::BYTE_W-1:0] mem_rdata;

  // Always take configuration writes
  assign cfg_ready = 1'b1;

  sletx_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .codes    (codes)
  );

  sletx_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  sletx_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .codes             (codes),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_payload_byte   (in_payload_byte),
    .in_done_position  (in_done_position),
    .in_read_position  (in_read_position),
    .mem_req           (mem_req),
    .mem_rdata         (mem_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_send_request  (out_send_request),
    .out_run_start     (out_run_start),
    .out_run_stop      (out_run_stop),
    .out_dropped_bytes (out_dropped_bytes),
    .out_read_byte     (out_read_byte)
  );

endmodule

`default_nettype wire

>>> tb/slip_escape_tx_ring_buffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slip_escape_tx_ring_buffer_tb: self-checking bench for the SLIP transmit ring
// Offers framing, data, send-done and read transactions with random idling on
// both channels, mirrors the ring buffer to predict every result and compares
// each field. Covers default, random, all-zero and all-ones code settings, a
// buffer-full phase, and a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module slip_escape_tx_ring_buffer_tb;

  localparam int unsigned DEPTH  = sletx_pkg::DEPTH;
  localparam int unsigned PTR_W  = sletx_pkg::PTR_W;
  localparam int unsigned POS_W  = sletx_pkg::POS_W;
  localparam int unsigned BYTE_W = sletx_pkg::BYTE_W;
  localparam int unsigned CMD_W  = sletx_pkg::CMD_W;
  localparam int unsigned IDX_W  = sletx_pkg::IDX_W;
  localparam int unsigned DROP_W = sletx_pkg::DROP_W;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [POS_W-1:0] RUN_END = POS_W'(DEPTH);

  typedef struct {
    sletx_pkg::cmd_t   cmd;
    logic [BYTE_W-1:0] payload;
    logic [POS_W-1:0]  done_pos;
    logic [PTR_W-1:0]  read_pos;
  } link_item_t;

  typedef struct {
    logic              send_request;
    logic [PTR_W-1:0]  run_start;
    logic [POS_W-1:0]  run_stop;
    logic [DROP_W-1:0] dropped;
    logic [BYTE_W-1:0] read_byte;
  } frame_result_t;

  // Clock, reset and block ports
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_cmd           = '0;
  logic [BYTE_W-1:0] in_payload_byte  = '0;
  logic [POS_W-1:0]  in_done_position = '0;
  logic [PTR_W-1:0]  in_read_position = '0;

  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic              out_send_request;
  logic [PTR_W-1:0]  out_run_start;
  logic [POS_W-1:0]  out_run_stop;
  logic [DROP_W-1:0] out_dropped_bytes;
  logic [BYTE_W-1:0] out_read_byte;

  logic              cfg_valid        = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index        = '0;
  logic [BYTE_W-1:0] cfg_data         = '0;

  // Bench bookkeeping
  link_item_t    pending_items[$];
  frame_result_t expected_results[$];
  int unsigned   items_sent   = 0;
  int unsigned   items_taken  = 0;
  int unsigned   failures     = 0;
  int unsigned   cycle_count  = 0;
  int unsigned   in_gap_left  = 0;
  int unsigned   out_gap_left = 0;
  int unsigned   hold_left    = 0;
  bit            hold_req     = 1'b0;
  bit            hold_served  = 1'b0;
  bit            no_idle      = 1'b0;
  logic          in_accepted  = 1'b0;
  logic          out_accepted = 1'b0;

  // Mirror of the ring buffer and code registers
  logic [BYTE_W-1:0] tx_mirror [DEPTH];
  bit                written_slot [DEPTH];
  logic [PTR_W-1:0]  mirror_head;
  logic [PTR_W-1:0]  mirror_tail;
  logic              mirror_busy;
  logic [POS_W-1:0]  mirror_run_stop;
  sletx_pkg::codes_t mirror_codes;

  slip_escape_tx_ring_buffer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_payload_byte   (in_payload_byte),
    .in_done_position  (in_done_position),
    .in_read_position  (in_read_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_send_request  (out_send_request),
    .out_run_start     (out_run_start),
    .out_run_stop      (out_run_stop),
    .out_dropped_bytes (out_dropped_bytes),
    .out_read_byte     (out_read_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // Start a send run if the link is idle and something is queued
  function automatic void begin_run(inout frame_result_t r);
    if (!mirror_busy && mirror_tail != mirror_head) begin
      mirror_busy     = 1'b1;
      r.send_request  = 1'b1;
      r.run_start     = mirror_tail;
      r.run_stop      = (mirror_tail < mirror_head) ? {1'b0, mirror_head} : RUN_END;
      mirror_run_stop = r.run_stop;
    end
  endfunction

  // Queue one byte, or drop it when the spare slot would be used
  function automatic void stash_byte(input logic [BYTE_W-1:0] b, inout frame_result_t r);
    logic [PTR_W-1:0] nxt;
    nxt = mirror_head + 1'b1;  // pointer width spans the buffer exactly
    if (nxt == mirror_tail) begin
      r.dropped = r.dropped + 1'b1;
    end else begin
      tx_mirror[mirror_head]    = b;
      written_slot[mirror_head] = 1'b1;
      mirror_head               = nxt;
      begin_run(r);
    end
  endfunction

  // Compute the result of one transaction and advance the mirror
  function automatic frame_result_t encode_item(link_item_t it);
    frame_result_t r;
    r.send_request = 1'b0;
    r.run_start    = '0;
    r.run_stop     = '0;
    r.dropped      = '0;
    r.read_byte    = '0;
    case (it.cmd)
      sletx_pkg::CMD_DATA: begin
        // First matching code wins: begin, then end, then escape
        if (it.payload == mirror_codes.code_begin) begin
          stash_byte(mirror_codes.code_escape, r);
          stash_byte(mirror_codes.code_esc_begin, r);
        end else if (it.payload == mirror_codes.code_end) begin
          stash_byte(mirror_codes.code_escape, r);
          stash_byte(mirror_codes.code_esc_end, r);
        end else if (it.payload == mirror_codes.code_escape) begin
          stash_byte(mirror_codes.code_escape, r);
          stash_byte(mirror_codes.code_esc_escape, r);
        end else begin
          stash_byte(it.payload, r);
        end
      end
      sletx_pkg::CMD_BEGIN: stash_byte(mirror_codes.code_begin, r);
      sletx_pkg::CMD_END:   stash_byte(mirror_codes.code_end, r);
      sletx_pkg::CMD_DONE: begin
        mirror_busy = 1'b0;
        mirror_tail = (it.done_pos >= DEPTH) ? '0 : it.done_pos[PTR_W-1:0];
        begin_run(r);
      end
      sletx_pkg::CMD_READ: r.read_byte = tx_mirror[it.read_pos];
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // Monitor: capture accepted transactions, check accepted results
  always @(posedge clk) begin : monitor_proc
    link_item_t    seen;
    frame_result_t want;
    if (!rst_n) begin
      in_accepted  <= 1'b0;
      out_accepted <= 1'b0;
    end else begin
      in_accepted  <= in_valid && !in_stall;
      out_accepted <= out_valid && !out_stall;
      if (in_valid && !in_stall) begin
        seen.cmd      = sletx_pkg::cmd_t'(in_cmd);
        seen.payload  = in_payload_byte;
        seen.done_pos = in_done_position;
        seen.read_pos = in_read_position;
        expected_results.push_back(encode_item(seen));
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing pending");
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("send_request", 16'(want.send_request), 16'(out_send_request));
          check_field("run_start", 16'(want.run_start), 16'(out_run_start));
          check_field("run_stop", 16'(want.run_stop), 16'(out_run_stop));
          check_field("dropped_bytes", 16'(want.dropped), 16'(out_dropped_bytes));
          check_field("read_byte", 16'(want.read_byte), 16'(out_read_byte));
        end
      end
    end
  end

  // Driver: present queued transactions with a random gap before each
  always @(negedge clk) begin : driver_proc
    link_item_t it;
    logic       drive_valid;
    drive_valid = in_valid;
    if (in_valid && in_accepted) drive_valid = 1'b0;
    if (rst_n && !drive_valid) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_cmd           <= it.cmd;
        in_payload_byte  <= it.payload;
        in_done_position <= it.done_pos;
        in_read_position <= it.read_pos;
        drive_valid = 1'b1;
        in_gap_left = no_idle ? 0 : $urandom_range(0, 10);
      end
    end
    in_valid <= drive_valid;
  end

  // Long receiver hold-off, armed once by the stimulus
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_served) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end
  end

  // Receiver: stall for a random count after each accepted result
  always @(negedge clk) begin
    if (out_accepted) out_gap_left = no_idle ? 0 : $urandom_range(0, 10);
    out_stall <= (hold_left != 0) || (out_gap_left != 0);
    if (out_gap_left != 0) out_gap_left--;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("slip_escape_tx_ring_buffer_tb NOT OK");
      $finish;
    end
  end

  // Queue one transaction; fill unused fields with noise
  task automatic offer_cmd(sletx_pkg::cmd_t c, int unsigned arg);
    link_item_t it;
    it.cmd      = c;
    it.payload  = BYTE_W'($urandom);
    it.done_pos = POS_W'($urandom_range(0, DEPTH));
    it.read_pos = PTR_W'($urandom);
    case (c)
      sletx_pkg::CMD_DATA: it.payload  = BYTE_W'(arg);
      sletx_pkg::CMD_DONE: it.done_pos = POS_W'(arg);
      sletx_pkg::CMD_READ: it.read_pos = PTR_W'(arg);
      default: ;
    endcase
    while (pending_items.size() >= 2) @(negedge clk);
    pending_items.push_back(it);
    items_sent++;
  endtask

  // Report completion of the outstanding run once all prior work is mirrored
  task automatic finish_send();
    while (items_taken != items_sent) @(negedge clk);
    offer_cmd(sletx_pkg::CMD_DONE, mirror_busy ? 32'(mirror_run_stop) : 32'(mirror_tail));
  endtask

  // Read a slot that has already been written, else queue a begin marker
  task automatic offer_read();
    int slot;
    int base;
    slot = -1;
    base = $urandom_range(0, DEPTH - 1);
    for (int k = 0; k < DEPTH; k++)
      if (slot < 0 && written_slot[(base + k) % DEPTH]) slot = (base + k) % DEPTH;
    if (slot >= 0) offer_cmd(sletx_pkg::CMD_READ, slot);
    else offer_cmd(sletx_pkg::CMD_BEGIN, 0);
  endtask

  // Data byte biased toward the special codes and the extremes
  task automatic offer_payload();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 9))
      0: b = mirror_codes.code_begin;
      1: b = mirror_codes.code_end;
      2: b = mirror_codes.code_escape;
      3: b = 8'h00;
      4: b = 8'hFF;
      default: b = BYTE_W'($urandom);
    endcase
    offer_cmd(sletx_pkg::CMD_DATA, 32'(b));
  endtask

  task automatic wait_idle();
    while (items_taken != items_sent || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_code(sletx_pkg::cfg_idx_t idx, logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sletx_pkg::REG_CODE_BEGIN:   mirror_codes.code_begin      = val;
      sletx_pkg::REG_CODE_END:     mirror_codes.code_end        = val;
      sletx_pkg::REG_CODE_ESC:     mirror_codes.code_escape     = val;
      sletx_pkg::REG_CODE_ESC_BEG: mirror_codes.code_esc_begin  = val;
      sletx_pkg::REG_CODE_ESC_END: mirror_codes.code_esc_end    = val;
      sletx_pkg::REG_CODE_ESC_ESC: mirror_codes.code_esc_escape = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_codes(logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] e,
                             logic [BYTE_W-1:0] esc, logic [BYTE_W-1:0] eb,
                             logic [BYTE_W-1:0] ee, logic [BYTE_W-1:0] eesc);
    wait_idle();
    write_code(sletx_pkg::REG_CODE_BEGIN, b);
    write_code(sletx_pkg::REG_CODE_END, e);
    write_code(sletx_pkg::REG_CODE_ESC, esc);
    write_code(sletx_pkg::REG_CODE_ESC_BEG, eb);
    write_code(sletx_pkg::REG_CODE_ESC_END, ee);
    write_code(sletx_pkg::REG_CODE_ESC_ESC, eesc);
  endtask

  // Random code set
  task automatic apply_random_codes();
    apply_codes(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
  endtask

  // Mostly well-formed packets, with sends completed, reads and some noise
  task automatic run_phase(int unsigned n_items, int unsigned done_pct, int unsigned noise_pct);
    int unsigned roll;
    int unsigned pkt_left;
    pkt_left = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      no_idle = (i < 30);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        offer_read();
      end else if (roll < 8 + done_pct) begin
        finish_send();
      end else if (roll < 8 + done_pct + noise_pct) begin
        offer_cmd(sletx_pkg::CMD_DONE, $urandom_range(0, DEPTH));
      end else if (roll < 8 + done_pct + 2 * noise_pct) begin
        offer_cmd($urandom_range(0, 1) ? sletx_pkg::CMD_BEGIN : sletx_pkg::CMD_END, 0);
      end else if (pkt_left == 0) begin
        offer_cmd(sletx_pkg::CMD_BEGIN, 0);
        pkt_left = $urandom_range(2, 14);
      end else if (pkt_left == 1) begin
        offer_cmd(sletx_pkg::CMD_END, 0);
        pkt_left = 0;
      end else begin
        offer_payload();
        pkt_left--;
      end
    end
    no_idle = 1'b0;
  endtask

  // Stimulus
  initial begin
    mirror_codes = {sletx_pkg::RST_CODE_BEGIN, sletx_pkg::RST_CODE_END,
                    sletx_pkg::RST_CODE_ESC, sletx_pkg::RST_CODE_ESC_BEG,
                    sletx_pkg::RST_CODE_ESC_END, sletx_pkg::RST_CODE_ESC_ESC};
    mirror_head     = '0;
    mirror_tail     = '0;
    mirror_busy     = 1'b0;
    mirror_run_stop = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: markers, byte extremes, every escape, send and read paths
    offer_cmd(sletx_pkg::CMD_BEGIN, 0);
    offer_cmd(sletx_pkg::CMD_DATA, 32'h00);
    offer_cmd(sletx_pkg::CMD_DATA, 32'hFF);
    offer_cmd(sletx_pkg::CMD_DATA, 32'(sletx_pkg::RST_CODE_BEGIN));
    offer_cmd(sletx_pkg::CMD_DATA, 32'(sletx_pkg::RST_CODE_END));
    offer_cmd(sletx_pkg::CMD_DATA, 32'(sletx_pkg::RST_CODE_ESC));
    offer_cmd(sletx_pkg::CMD_END, 0);
    finish_send();
    offer_cmd(sletx_pkg::CMD_READ, 0);
    offer_cmd(sletx_pkg::CMD_READ, 8);
    finish_send();
    // send done with the link already idle
    finish_send();
    // link idle and empty: request lands between escape and substitute
    offer_cmd(sletx_pkg::CMD_DATA, 32'(sletx_pkg::RST_CODE_ESC));
    // done at the buffer end wraps the tail to zero
    offer_cmd(sletx_pkg::CMD_DONE, DEPTH);
    finish_send();
    offer_cmd(sletx_pkg::CMD_DATA, 32'h55);
    offer_cmd(sletx_pkg::CMD_DATA, 32'hAA);
    offer_cmd(sletx_pkg::CMD_READ, 10);
    offer_cmd(sletx_pkg::CMD_DONE, 0);

    // Random phases across code settings
    apply_codes(sletx_pkg::RST_CODE_BEGIN, sletx_pkg::RST_CODE_END,
                sletx_pkg::RST_CODE_ESC, sletx_pkg::RST_CODE_ESC_BEG,
                sletx_pkg::RST_CODE_ESC_END, sletx_pkg::RST_CODE_ESC_ESC);
    run_phase(110, 30, 3);

    // Fill the ring without completing sends; hold the receiver off meanwhile
    apply_random_codes();
    hold_req = 1'b1;
    run_phase(280, 0, 0);

    // All codes equal: begin match takes priority
    apply_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_phase(90, 30, 3);

    apply_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_phase(90, 30, 3);

    apply_random_codes();
    run_phase(80, 30, 3);

    wait_idle();
    if (failures == 0 && expected_results.size() == 0) begin
      $display("slip_escape_tx_ring_buffer_tb OK");
    end else begin
      $display("slip_escape_tx_ring_buffer_tb NOT OK");
    end
    $finish;
  end

endmodule
